>>> design/lbfs_pkg.sv
// Shared types and constants for the LED blink and flash sequencer.
package lbfs_pkg;

    localparam int MODE_W    = 3;
    localparam int SEL_W     = 2;
    localparam int LED_OUT_W = 3;
    localparam int MS_W      = 16;
    localparam int TOG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Command codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BLINK = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FLASH = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    localparam logic [SEL_W-1:0] SEL_ALL = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_HALF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TOG  = 2'd2;

    localparam logic [MS_W-1:0]  BLINK_MS_RST   = 16'd500;
    localparam logic [MS_W-1:0]  FLASH_HALF_RST = 16'd100;
    localparam logic [TOG_W-1:0] FLASH_TOG_RST  = 8'd10;

    // Decoded command of an accepted transaction (at most one bit set)
    typedef struct packed {
        logic tick;
        logic set;
        logic blink;
        logic start;
        logic clr;
    } cmd_t;

    // Flash sequencer status towards the LED register
    typedef struct packed {
        logic busy;       // flash running before this transaction
        logic busy_next;  // flash running after this transaction
        logic fire;       // flash event on this tick
        logic light;      // event lights all LEDs (else darkens them)
    } flash_stat_t;

endpackage

>>> design/lbfs_blink.sv
// Per-LED one-shot blink countdown lanes.
module lbfs_blink #(
    parameter int LED_COUNT = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lbfs_pkg::cmd_t             cmd,
    input  logic                       flash_busy,
    input  logic [lbfs_pkg::SEL_W-1:0] sel,
    input  logic [lbfs_pkg::MS_W-1:0]  blink_ms,
    output logic [LED_COUNT-1:0]       expire
);
    import lbfs_pkg::*;

    localparam int NLED = (LED_COUNT < 3) ? LED_COUNT : 3;

    genvar i;
    generate
        for (i = 0; i < LED_COUNT; i++) begin : g_lane
            if (i < NLED) begin : g_used
                logic            active_reg, active_next;
                logic [MS_W-1:0] rem_reg, rem_next;
                logic            load;
                logic            run;

                assign load = cmd.blink && !flash_busy && (sel == SEL_W'(i));
                assign run  = cmd.tick && !flash_busy && active_reg;
                assign expire[i] = run && (rem_reg == '0);

                always_comb begin
                    active_next = active_reg;
                    rem_next    = rem_reg;
                    if (cmd.clr || cmd.start) begin
                        active_next = 1'b0;
                    end else if (load) begin
                        active_next = 1'b1;
                        rem_next    = blink_ms;
                    end else if (run) begin
                        if (rem_reg == '0) begin
                            active_next = 1'b0;
                        end else begin
                            rem_next = rem_reg - 1'b1;
                        end
                    end
                end

                always_ff @(posedge aclk) begin
                    if (!aresetn) begin
                        active_reg <= 1'b0;
                    end else begin
                        active_reg <= active_next;
                    end
                    rem_reg <= rem_next;
                end
            end else begin : g_none
                assign expire[i] = 1'b0;
            end
        end
    endgenerate

endmodule

>>> design/lbfs_flash.sv
// All-LED flash sequencer: phase, half-period countdown and off-phase count.
module lbfs_flash (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lbfs_pkg::cmd_t             cmd,
    input  logic [lbfs_pkg::MS_W-1:0]  flash_half_ms,
    input  logic [lbfs_pkg::TOG_W-1:0] flash_toggles,
    output lbfs_pkg::flash_stat_t      stat
);
    import lbfs_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ON   = 2'd1;
    localparam logic [1:0] PH_OFF  = 2'd2;

    logic [1:0]       phase_reg, phase_next;
    logic [TOG_W-1:0] done_reg, done_next;
    logic [MS_W-1:0]  rem_reg, rem_next;
    logic             busy, fire, light;
    logic [1:0]       ev_phase;
    logic [TOG_W-1:0] ev_done;

    assign busy = (phase_reg != PH_IDLE);
    assign fire = cmd.tick && busy && (rem_reg == '0);

    // Outcome of a flash event, including the end of the sequence
    always_comb begin
        if (phase_reg == PH_ON) begin
            ev_phase = PH_OFF;
            ev_done  = done_reg;
            light    = 1'b1;
        end else begin
            ev_phase = PH_ON;
            ev_done  = done_reg + 1'b1;
            light    = 1'b0;
        end
        if (ev_done >= flash_toggles) begin
            ev_phase = PH_IDLE;
            ev_done  = '0;
            light    = 1'b0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        done_next  = done_reg;
        rem_next   = rem_reg;
        if (cmd.clr) begin
            phase_next = PH_IDLE;
            done_next  = '0;
        end else if (cmd.start) begin
            phase_next = PH_ON;
            done_next  = '0;
            rem_next   = flash_half_ms;
        end else if (cmd.tick && busy) begin
            if (rem_reg != '0) begin
                rem_next = rem_reg - 1'b1;
            end else begin
                phase_next = ev_phase;
                done_next  = ev_done;
                rem_next   = flash_half_ms;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            done_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        rem_reg <= rem_next;
    end

    assign stat.busy      = busy;
    assign stat.busy_next = (phase_next != PH_IDLE);
    assign stat.fire      = fire;
    assign stat.light     = light;

endmodule

>>> design/led_blink_flash_sequencer.sv
// Top level of the LED blink and flash sequencer.
// The result of a transaction is shown the cycle after acceptance.
// One transaction per cycle while the sink keeps up; every input transaction gives one result.
// The state update sits between the LED/timer registers and the output register.
// Reset (aresetn low, synchronous): LEDs dark, flash idle, blinks off, registers
// back to blink 500, half period 100, ten off phases; no result pending.
module led_blink_flash_sequencer #(
    parameter int LED_COUNT = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lbfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lbfs_pkg::CFG_DAT_W-1:0]      cfg_data,
    // command and tick transactions
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lbfs_pkg::MODE_W-1:0]         s_mode,
    input  logic [lbfs_pkg::SEL_W-1:0]          s_led_select,
    input  logic                                s_lit,
    // results
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lbfs_pkg::LED_OUT_W-1:0]      m_led_on,
    output logic                                m_flashing
);
    import lbfs_pkg::*;

    localparam int NLED = (LED_COUNT < 3) ? LED_COUNT : 3;
    localparam logic [LED_COUNT-1:0] ALL_MASK = {LED_COUNT{1'b1}};
    localparam logic [LED_COUNT-1:0] ONE_HOT0 = LED_COUNT'(1);
    localparam logic [LED_COUNT+LED_OUT_W-1:0] ALL_EXT = {{LED_OUT_W{1'b0}}, ALL_MASK};
    localparam logic [LED_OUT_W-1:0] ALL_OUT = ALL_EXT[LED_OUT_W-1:0];

    // ---------------------------------------------------------------
    // Configuration registers; writes are always taken
    // ---------------------------------------------------------------
    logic [MS_W-1:0]  blink_ms_reg;
    logic [MS_W-1:0]  flash_half_reg;
    logic [TOG_W-1:0] flash_tog_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_ms_reg   <= BLINK_MS_RST;
            flash_half_reg <= FLASH_HALF_RST;
            flash_tog_reg  <= FLASH_TOG_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BLINK_MS:   blink_ms_reg   <= cfg_data;
                CFG_FLASH_HALF: flash_half_reg <= cfg_data;
                CFG_FLASH_TOG:  flash_tog_reg  <= cfg_data[TOG_W-1:0];
                default: ;   // index beyond the register list is dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the output register frees up when its result is taken,
    // so a new transaction goes in every cycle the sink keeps up.
    // ---------------------------------------------------------------
    logic accept;
    logic m_valid_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Command decode, gated by acceptance so the state units only move then
    cmd_t cmd;
    always_comb begin
        cmd = '0;
        if (accept) begin
            case (s_mode)
                MODE_TICK:  cmd.tick  = 1'b1;
                MODE_SET:   cmd.set   = 1'b1;
                MODE_BLINK: cmd.blink = 1'b1;
                MODE_FLASH: cmd.start = 1'b1;
                MODE_CLEAR: cmd.clr   = 1'b1;
                default: ;   // unused modes leave the state alone
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Timer units
    // ---------------------------------------------------------------
    flash_stat_t          fstat;
    logic [LED_COUNT-1:0] expire;

    lbfs_flash u_flash (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .flash_half_ms (flash_half_reg),
        .flash_toggles (flash_tog_reg),
        .stat          (fstat)
    );

    lbfs_blink #(
        .LED_COUNT (LED_COUNT)
    ) u_blink (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .flash_busy (fstat.busy),
        .sel        (s_led_select),
        .blink_ms   (blink_ms_reg),
        .expire     (expire)
    );

    // ---------------------------------------------------------------
    // LED state
    // ---------------------------------------------------------------
    logic [LED_COUNT-1:0] lit_reg, lit_next;
    logic [LED_COUNT-1:0] sel_mask;
    logic                 sel_one;

    assign sel_one = (int'(s_led_select) < NLED);

    always_comb begin
        if (s_led_select == SEL_ALL) begin
            sel_mask = ALL_MASK;
        end else if (sel_one) begin
            sel_mask = ONE_HOT0 << s_led_select;
        end else begin
            sel_mask = '0;
        end
    end

    always_comb begin
        lit_next = lit_reg;
        if (cmd.clr) begin
            lit_next = '0;
        end else if (cmd.start) begin
            lit_next = lit_reg | ALL_MASK;
        end else if (cmd.tick) begin
            if (fstat.fire) begin
                lit_next = fstat.light ? ALL_MASK : '0;
            end else if (!fstat.busy) begin
                lit_next = lit_reg & ~expire;
            end
        end else if (cmd.set && !fstat.busy) begin
            lit_next = s_lit ? (lit_reg | sel_mask) : (lit_reg & ~sel_mask);
        end else if (cmd.blink && !fstat.busy && sel_one) begin
            lit_next = lit_reg | sel_mask;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_reg <= '0;
        end else begin
            lit_reg <= lit_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic [LED_COUNT+LED_OUT_W-1:0] lit_ext;
    logic [LED_OUT_W-1:0]           led_on_reg;
    logic                           flashing_reg;

    assign lit_ext = {{LED_OUT_W{1'b0}}, lit_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (accept) begin
            led_on_reg   <= lit_ext[LED_OUT_W-1:0];
            flashing_reg <= fstat.busy_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_led_on   = led_on_reg;
    assign m_flashing = flashing_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_CLEAR) |=>
            (m_valid && m_led_on == '0 && !m_flashing))
        else $error("clear command did not give a dark, idle result");

    a_flash_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_FLASH) |=>
            (m_valid && m_flashing && m_led_on == ALL_OUT))
        else $error("start flash did not light all LEDs");

    a_sink_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the LED blink and flash sequencer.
`timescale 1ns / 100ps

module tb_top;
    import lbfs_pkg::*;

    // LED indexes carried in the select field; SEL_ALL comes from the package
    localparam logic [SEL_W-1:0] LED_RED    = 2'd0;
    localparam logic [SEL_W-1:0] LED_YELLOW = 2'd1;
    localparam logic [SEL_W-1:0] LED_GREEN  = 2'd2;
    localparam int               LED_TOTAL  = 3;

    // Mode codes with no meaning; the block must leave its state alone
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    // Register index past the last register; writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [LED_OUT_W-1:0] LEDS_BRIGHT = 3'b111;
    localparam logic [LED_OUT_W-1:0] LEDS_DARK   = 3'b000;

    // Cycles with no transaction on any channel before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Random items per chunk; three idling regimes of four chunks each
    localparam int CHUNK_ITEMS = 96;

    typedef enum logic [1:0] {
        FL_IDLE,
        FL_ON,
        FL_OFF
    } flash_phase_t;

    typedef struct {
        logic [LED_OUT_W-1:0] led_on;
        logic                 flashing;
    } led_result_t;

    // ------------------------------------------------------------------
    // Clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------
    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_BLINK_MS;
    logic [CFG_DAT_W-1:0]  cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [MODE_W-1:0]     s_mode       = MODE_TICK;
    logic [SEL_W-1:0]      s_led_select = LED_RED;
    logic                  s_lit        = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [LED_OUT_W-1:0]  m_led_on;
    logic                  m_flashing;

    always #4 aclk = ~aclk;

    led_blink_flash_sequencer uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_led_select (s_led_select),
        .s_lit        (s_lit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_led_on     (m_led_on),
        .m_flashing   (m_flashing)
    );

    // ------------------------------------------------------------------
    // Mirror of the sequencer: register copies and LED/timer state
    // ------------------------------------------------------------------
    logic [MS_W-1:0]      blink_ms_cfg   = BLINK_MS_RST;
    logic [MS_W-1:0]      flash_half_cfg = FLASH_HALF_RST;
    logic [TOG_W-1:0]     flash_tog_cfg  = FLASH_TOG_RST;

    logic [LED_OUT_W-1:0] leds_lit       = LEDS_DARK;
    flash_phase_t         flash_phase    = FL_IDLE;
    logic [TOG_W-1:0]     off_phases     = '0;
    logic [MS_W-1:0]      flash_left     = '0;
    logic                 blink_on   [LED_TOTAL];
    logic [MS_W-1:0]      blink_left [LED_TOTAL];

    led_result_t led_results_due[$];

    int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
    int recv_stall_pct = 0;  // chance in a hundred that the receiver stalls a cycle
    int fail_count = 0;
    int quiet_cycles = 0;

    task automatic clear_leds();
        leds_lit    = LEDS_DARK;
        flash_phase = FL_IDLE;
        off_phases  = '0;
        flash_left  = '0;
        for (int i = 0; i < LED_TOTAL; i++) begin
            blink_on[i]   = 1'b0;
            blink_left[i] = '0;
        end
    endtask

    // One millisecond tick while a flash runs: countdown, then an event
    task automatic flash_ms_tick();
        if (flash_left != 0) begin
            flash_left = flash_left - 1'b1;
        end else begin
            if (flash_phase == FL_ON) begin
                leds_lit    = LEDS_BRIGHT;
                flash_phase = FL_OFF;
            end else begin
                leds_lit    = LEDS_DARK;
                flash_phase = FL_ON;
                off_phases  = off_phases + 1'b1;
            end
            flash_left = flash_half_cfg;
            // zero toggles ends the sequence on the very first event
            if (off_phases >= flash_tog_cfg) begin
                off_phases  = '0;
                flash_phase = FL_IDLE;
                leds_lit    = LEDS_DARK;
            end
        end
    endtask

    // One tick with no flash: each running blink counts down or goes dark
    task automatic blink_ms_tick();
        for (int i = 0; i < LED_TOTAL; i++) begin
            if (blink_on[i]) begin
                if (blink_left[i] == 0) begin
                    blink_on[i] = 1'b0;
                    leds_lit[i] = 1'b0;
                end else begin
                    blink_left[i] = blink_left[i] - 1'b1;
                end
            end
        end
    endtask

    // Applies one accepted transaction and queues the LED state it leaves
    task automatic advance_leds(input logic [MODE_W-1:0] mode,
                                input logic [SEL_W-1:0] sel, input logic lit);
        led_result_t res;
        case (mode)
            MODE_TICK: begin
                if (flash_phase != FL_IDLE) flash_ms_tick();
                else blink_ms_tick();
            end
            MODE_SET: begin
                if (flash_phase == FL_IDLE) begin
                    if (sel == SEL_ALL) leds_lit = lit ? LEDS_BRIGHT : LEDS_DARK;
                    else leds_lit[sel] = lit;
                end
            end
            MODE_BLINK: begin
                // blink on "all" is dropped
                if (flash_phase == FL_IDLE && sel != SEL_ALL) begin
                    blink_on[sel]   = 1'b1;
                    blink_left[sel] = blink_ms_cfg;
                    leds_lit[sel]   = 1'b1;
                end
            end
            MODE_FLASH: begin
                // also restarts a flash already running
                for (int i = 0; i < LED_TOTAL; i++) blink_on[i] = 1'b0;
                off_phases  = '0;
                flash_left  = flash_half_cfg;
                flash_phase = FL_ON;
                leds_lit    = LEDS_BRIGHT;
            end
            MODE_CLEAR: clear_leds();
            default: ;
        endcase
        res.led_on   = leds_lit;
        res.flashing = (flash_phase != FL_IDLE);
        led_results_due.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Transaction drivers
    // ------------------------------------------------------------------

    // Sends one command or tick; valid stays high into the next call unless
    // the sender decides to idle, so it is never dropped and raised in one step
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [SEL_W-1:0] sel, input logic lit);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_mode       <= mode;
        s_led_select <= sel;
        s_lit        <= lit;
        do @(posedge aclk); while (!s_ready);
        advance_leds(mode, sel, lit);
    endtask

    // Holds off the sender until every outstanding result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (led_results_due.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Register write; the block is idle whenever this is called
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BLINK_MS:   blink_ms_cfg   = data;
            CFG_FLASH_HALF: flash_half_cfg = data;
            CFG_FLASH_TOG:  flash_tog_cfg  = data[TOG_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver back-pressure, result checking and watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        led_result_t due;
        if (aresetn && m_valid && m_ready) begin
            if (led_results_due.size() == 0) begin
                $error("unexpected result: led_on %0h flashing %0b", m_led_on, m_flashing);
                fail_count++;
            end else begin
                due = led_results_due.pop_front();
                if (m_led_on !== due.led_on) begin
                    $error("led_on: expected %0h actual %0h", due.led_on, m_led_on);
                    fail_count++;
                end
                if (m_flashing !== due.flashing) begin
                    $error("flashing: expected %0b actual %0b", due.flashing, m_flashing);
                    fail_count++;
                end
            end
        end
    end

    // Counts cycles in which no transaction moves on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Set on each LED and on all, both polarities; spare modes change nothing
    task automatic test_set_and_spare_modes();
        send_item(MODE_SET, LED_RED, 1'b1);
        send_item(MODE_SET, LED_YELLOW, 1'b1);
        send_item(MODE_SET, LED_GREEN, 1'b1);
        send_item(MODE_SET, LED_YELLOW, 1'b0);
        send_item(MODE_SET, SEL_ALL, 1'b0);
        send_item(MODE_SET, SEL_ALL, 1'b1);
        for (logic [MODE_W-1:0] m = MODE_SPARE_LO; m <= MODE_SPARE_LO + 3'd1; m++)
            send_item(m, SEL_ALL, 1'b1);
        send_item(MODE_SPARE_HI, SEL_ALL, 1'b1);
        send_item(MODE_CLEAR, SEL_ALL, 1'b1);
        drain_results();
    endtask

    // Zero and one millisecond blinks; blink on all is dropped
    task automatic test_blink();
        write_reg(CFG_BLINK_MS, '0);
        send_item(MODE_BLINK, LED_RED, 1'b0);
        send_item(MODE_TICK, LED_RED, 1'b0);
        send_item(MODE_BLINK, SEL_ALL, 1'b1);
        drain_results();
        write_reg(CFG_BLINK_MS, 16'd1);
        send_item(MODE_BLINK, LED_GREEN, 1'b1);
        send_item(MODE_TICK, LED_GREEN, 1'b1);
        send_item(MODE_TICK, LED_GREEN, 1'b1);
        drain_results();
    endtask

    // Flash with zero half period, commands ignored meanwhile, restart,
    // clear command mid-flash, and zero toggles (upper data bits set)
    task automatic test_flash();
        write_reg(CFG_FLASH_HALF, '0);
        write_reg(CFG_FLASH_TOG, 16'h0001);
        send_item(MODE_BLINK, LED_YELLOW, 1'b1);
        send_item(MODE_FLASH, LED_RED, 1'b0);
        send_item(MODE_SET, SEL_ALL, 1'b0);
        send_item(MODE_BLINK, LED_RED, 1'b1);
        send_item(MODE_TICK, LED_RED, 1'b0);
        send_item(MODE_FLASH, LED_RED, 1'b0);
        send_item(MODE_TICK, LED_RED, 1'b0);
        send_item(MODE_TICK, LED_RED, 1'b0);
        send_item(MODE_FLASH, LED_RED, 1'b0);
        send_item(MODE_CLEAR, LED_RED, 1'b0);
        drain_results();
        write_reg(CFG_FLASH_TOG, 16'hFF00);
        send_item(MODE_FLASH, LED_RED, 1'b0);
        send_item(MODE_TICK, LED_RED, 1'b0);
        drain_results();
    endtask

    // Largest register values, and a write to the spare index
    task automatic test_config_extremes();
        write_reg(CFG_BLINK_MS, 16'hFFFF);
        write_reg(CFG_FLASH_HALF, 16'hFFFF);
        write_reg(CFG_FLASH_TOG, 16'h00FF);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_item(MODE_BLINK, LED_RED, 1'b1);
        send_item(MODE_TICK, LED_RED, 1'b1);
        send_item(MODE_FLASH, LED_RED, 1'b1);
        send_item(MODE_TICK, LED_RED, 1'b1);
        send_item(MODE_CLEAR, LED_RED, 1'b1);
        drain_results();
    endtask

    // Short timings most of the time so blinks and flashes run to the end
    task automatic pick_random_setting();
        if ($urandom_range(0, 7) == 0) begin
            write_reg(CFG_BLINK_MS, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            write_reg(CFG_FLASH_HALF, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
            write_reg(CFG_FLASH_TOG, $urandom_range(0, 1) ? 16'h00FF : 16'h0000);
        end else begin
            write_reg(CFG_BLINK_MS, 16'($urandom_range(0, 12)));
            write_reg(CFG_FLASH_HALF, 16'($urandom_range(0, 4)));
            // random upper byte is dropped by the eight-bit register
            write_reg(CFG_FLASH_TOG, {8'($urandom), 8'($urandom_range(0, 5))});
        end
        if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom));
    endtask

    // Mostly ticks with commands sprinkled in; a few spare modes as noise
    task automatic random_items(input int count);
        logic [MODE_W-1:0] mode;
        int                pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 58)      mode = MODE_TICK;
            else if (pick < 70) mode = MODE_SET;
            else if (pick < 82) mode = MODE_BLINK;
            else if (pick < 89) mode = MODE_FLASH;
            else if (pick < 93) mode = MODE_CLEAR;
            else                mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
            send_item(mode, SEL_W'($urandom_range(LED_RED, SEL_ALL)),
                      1'($urandom_range(0, 1)));
        end
        drain_results();
    endtask

    // Random traffic under one idling regime, registers changed between chunks
    task automatic test_random(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int c = 0; c < 4; c++) begin
            pick_random_setting();
            random_items(CHUNK_ITEMS);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin
        clear_leds();
        send_idle_pct  = 37;
        recv_stall_pct = 55;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_set_and_spare_modes();
        test_blink();
        test_flash();
        test_config_extremes();

        test_random(37, 55);
        test_random(55, 37);
        test_random(0, 0);

        // wait for any stray result before the final check
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && led_results_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
